// ===== hdl/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// Line stepper package
// Shared widths, codes and transfer payload types for the patterned
// Bresenham line stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

  localparam int COORD_BITS  = 12;
  // The error term spans -abs_dy .. +abs_dx plus one step, so two extra bits.
  localparam int ERR_BITS    = COORD_BITS + 2;

  localparam int DOT_PERIOD  = 4;
  localparam int DASH_PERIOD = 10;
  localparam int DASH_ON     = 5;
  localparam int DOT_BITS    = $clog2(DOT_PERIOD);
  localparam int DASH_BITS   = $clog2(DASH_PERIOD);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    PAT_SOLID  = 2'd0,
    PAT_DOTTED = 2'd1,
    PAT_DASHED = 2'd2,
    PAT_NONE   = 2'd3
  } pattern_t;

  typedef struct packed {
    req_kind_t req_type;
    coord_t    from_x;
    coord_t    from_y;
    coord_t    to_x;
    coord_t    to_y;
    pattern_t  pattern_kind;
  } req_item_t;

  typedef struct packed {
    logic   pixel_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   plot;
    logic   last_pixel;
  } rsp_item_t;

endpackage

`default_nettype wire

// ===== hdl/bresenham_line_stepper_patterned.sv =====
// A request's result is registered and shown in the cycle after its transfer.
// Throughput: one request per cycle; the step, pattern and endpoint logic
// all sit between the line state registers and the result register.
// Input and output stall only when a held result is not taken.
// Reset clears the active line, the pattern phases and the result valid.
// ----------------------------------------------------------------------------
// Patterned Bresenham line stepper
// Start requests load a line; step requests return its pixels in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_stepper_patterned (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire bls_pkg::req_item_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output bls_pkg::rsp_item_t      rsp
);

  logic               fire;
  bls_pkg::rsp_item_t result;

  assign fire = req_valid && req_ready;

  bls_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .req    (req),
    .result (result)
  );

  bls_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .data      (result),
    .can_load  (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== hdl/bls_engine.sv =====
// ----------------------------------------------------------------------------
// Line stepper engine
// Holds the line state and does one Bresenham step, pattern decision and
// endpoint check per accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire bls_pkg::req_item_t req,
  output bls_pkg::rsp_item_t     result
);

  localparam int EB = bls_pkg::ERR_BITS;
  localparam int E2_BITS = EB + 1;

  bls_pkg::coord_t pos_x, pos_y, goal_x, goal_y, abs_dx, abs_dy;
  logic            dir_x_neg, dir_y_neg;
  logic signed [EB-1:0] err_acc;
  logic [bls_pkg::DOT_BITS-1:0]  dot_phase;
  logic [bls_pkg::DASH_BITS-1:0] dash_phase;
  bls_pkg::pattern_t line_pattern;
  logic            line_active;

  bls_pkg::coord_t pos_x_next, pos_y_next, abs_dx_next, abs_dy_next;
  logic signed [EB-1:0] err_acc_next;
  logic signed [E2_BITS-1:0] e2, dx_ext, dy_neg;
  logic step_x, step_y, last, plot;
  logic [bls_pkg::DOT_BITS-1:0]  dot_phase_next;
  logic [bls_pkg::DASH_BITS-1:0] dash_phase_next;

  // Step decision from the current error term.
  always_comb begin
    e2     = {err_acc, 1'b0};
    dx_ext = E2_BITS'(abs_dx);
    dy_neg = -E2_BITS'(abs_dy);
    step_x = e2 > dy_neg;
    step_y = e2 < dx_ext;
    err_acc_next = err_acc + (step_y ? EB'(abs_dx) : '0) - (step_x ? EB'(abs_dy) : '0);
    pos_x_next = dir_x_neg ? pos_x - 1'b1 : pos_x + 1'b1;
    pos_y_next = dir_y_neg ? pos_y - 1'b1 : pos_y + 1'b1;
    dot_phase_next = (dot_phase == bls_pkg::DOT_BITS'(bls_pkg::DOT_PERIOD - 1)) ?
                     '0 : dot_phase + 1'b1;
    dash_phase_next = (dash_phase == bls_pkg::DASH_BITS'(bls_pkg::DASH_PERIOD - 1)) ?
                      '0 : dash_phase + 1'b1;
    abs_dx_next = (req.to_x > req.from_x) ? req.to_x - req.from_x : req.from_x - req.to_x;
    abs_dy_next = (req.to_y > req.from_y) ? req.to_y - req.from_y : req.from_y - req.to_y;
  end

  always_comb begin
    unique case (line_pattern)
      bls_pkg::PAT_SOLID:  plot = 1'b1;
      bls_pkg::PAT_DOTTED: plot = (dot_phase == '0);
      bls_pkg::PAT_DASHED: plot = (dash_phase < bls_pkg::DASH_BITS'(bls_pkg::DASH_ON));
      default:             plot = 1'b0;
    endcase
    last = (pos_x == goal_x) && (pos_y == goal_y);
  end

  // Start requests and steps without a line give an all-zero result.
  always_comb begin
    result = '0;
    if (req.req_type == bls_pkg::REQ_STEP && line_active) begin
      result.pixel_valid = 1'b1;
      result.pixel_x     = pos_x;
      result.pixel_y     = pos_y;
      result.plot        = plot;
      result.last_pixel  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= '0;
      pos_y        <= '0;
      goal_x       <= '0;
      goal_y       <= '0;
      abs_dx       <= '0;
      abs_dy       <= '0;
      dir_x_neg    <= 1'b0;
      dir_y_neg    <= 1'b0;
      err_acc      <= '0;
      line_pattern <= bls_pkg::PAT_SOLID;
      line_active  <= 1'b0;
      dot_phase    <= '0;
      dash_phase   <= '0;
    end else if (fire) begin
      if (req.req_type == bls_pkg::REQ_START) begin
        pos_x        <= req.from_x;
        pos_y        <= req.from_y;
        goal_x       <= req.to_x;
        goal_y       <= req.to_y;
        abs_dx       <= abs_dx_next;
        abs_dy       <= abs_dy_next;
        dir_x_neg    <= !(req.from_x < req.to_x);
        dir_y_neg    <= !(req.from_y < req.to_y);
        err_acc      <= EB'(abs_dx_next) - EB'(abs_dy_next);
        dot_phase    <= '0;
        dash_phase   <= '0;
        line_pattern <= req.pattern_kind;
        line_active  <= 1'b1;
      end else if (line_active) begin
        if (last) begin
          line_active <= 1'b0;
        end else begin
          if (step_x) pos_x <= pos_x_next;
          if (step_y) pos_y <= pos_y_next;
          err_acc    <= err_acc_next;
          dot_phase  <= dot_phase_next;
          dash_phase <= dash_phase_next;
        end
      end
    end
  end

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    fire && req.req_type == bls_pkg::REQ_STEP && line_active && last |=> !line_active)
    else $error("line still active after its end point was given");

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    fire && req.req_type == bls_pkg::REQ_START
    |=> line_active && dot_phase == '0 && dash_phase == '0)
    else $error("start did not arm a fresh line");

  a_dash_range: assert property (@(posedge clk) disable iff (rst)
    dash_phase < bls_pkg::DASH_BITS'(bls_pkg::DASH_PERIOD))
    else $error("dash phase out of range");

  a_idle_step_empty: assert property (@(posedge clk) disable iff (rst)
    !line_active |-> !result.pixel_valid && !result.plot && !result.last_pixel)
    else $error("pixel given with no active line");

endmodule

`default_nettype wire

// ===== hdl/bls_out_reg.sv =====
// ----------------------------------------------------------------------------
// Line stepper result register
// Holds one result until the downstream transfer completes; a new request
// is taken in the same cycle the held result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire bls_pkg::rsp_item_t data,
  output logic                    can_load,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output bls_pkg::rsp_item_t      rsp
);

  assign can_load = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= data;
    end
  end

endmodule

`default_nettype wire

// ===== tb/bls_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// Line stepper pixel checker
// Watches both channels of the patterned Bresenham line stepper, traces each
// accepted request through its own line and pattern state, and compares
// every accepted pixel result against the oldest traced one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bls_pixel_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire logic               req_ready,
  input  wire bls_pkg::req_item_t req,
  input  wire logic               rsp_valid,
  input  wire logic               rsp_ready,
  input  wire bls_pkg::rsp_item_t rsp,
  output int unsigned             fail_count,
  output int unsigned             open_count
);

  bls_pkg::coord_t                     cur_x, cur_y, end_x, end_y, span_x, span_y;
  logic                                x_down, y_down;
  logic signed [bls_pkg::ERR_BITS-1:0] err_term;
  logic [bls_pkg::DOT_BITS-1:0]        dot_ph;
  logic [bls_pkg::DASH_BITS-1:0]       dash_ph;
  bls_pkg::pattern_t                   line_pat;
  logic                                drawing;

  bls_pkg::rsp_item_t pixel_expect_q[$];

  // Applies one request to the traced line and returns the pixel it yields.
  function automatic bls_pkg::rsp_item_t trace_pixel(input bls_pkg::req_item_t r);
    bls_pkg::rsp_item_t o;
    int                 e2;
    o = '0;
    if (r.req_type == bls_pkg::REQ_START) begin
      cur_x    = r.from_x;
      cur_y    = r.from_y;
      end_x    = r.to_x;
      end_y    = r.to_y;
      span_x   = (r.to_x > r.from_x) ? r.to_x - r.from_x : r.from_x - r.to_x;
      span_y   = (r.to_y > r.from_y) ? r.to_y - r.from_y : r.from_y - r.to_y;
      // An axis with no travel still counts as stepping downward.
      x_down   = !(r.from_x < r.to_x);
      y_down   = !(r.from_y < r.to_y);
      err_term = $signed({2'b00, span_x}) - $signed({2'b00, span_y});
      dot_ph   = '0;
      dash_ph  = '0;
      line_pat = r.pattern_kind;
      drawing  = 1'b1;
      return o;
    end
    if (!drawing) return o;

    o.pixel_valid = 1'b1;
    o.pixel_x     = cur_x;
    o.pixel_y     = cur_y;
    case (line_pat)
      bls_pkg::PAT_SOLID:  o.plot = 1'b1;
      bls_pkg::PAT_DOTTED: o.plot = (dot_ph == 0);
      bls_pkg::PAT_DASHED: o.plot = (dash_ph < bls_pkg::DASH_ON);
      default:             o.plot = 1'b0;
    endcase
    o.last_pixel = (cur_x == end_x) && (cur_y == end_y);
    if (o.last_pixel) begin
      drawing = 1'b0;
      return o;
    end

    e2 = 2 * int'(err_term);
    if (e2 > -int'(span_y)) begin
      err_term = err_term - $signed({2'b00, span_y});
      cur_x    = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
    end
    if (e2 < int'(span_x)) begin
      err_term = err_term + $signed({2'b00, span_x});
      cur_y    = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
    end
    dot_ph  = (dot_ph == bls_pkg::DOT_PERIOD - 1) ? '0 : dot_ph + 1'b1;
    dash_ph = (dash_ph == bls_pkg::DASH_PERIOD - 1) ? '0 : dash_ph + 1'b1;
    return o;
  endfunction

  function automatic void check_field(input string what,
                                      input logic [bls_pkg::COORD_BITS-1:0] want,
                                      input logic [bls_pkg::COORD_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    bls_pkg::rsp_item_t want;
    if (rst) begin
      cur_x      = '0;
      cur_y      = '0;
      end_x      = '0;
      end_y      = '0;
      span_x     = '0;
      span_y     = '0;
      x_down     = 1'b0;
      y_down     = 1'b0;
      err_term   = '0;
      dot_ph     = '0;
      dash_ph    = '0;
      line_pat   = bls_pkg::PAT_SOLID;
      drawing    = 1'b0;
      fail_count = 0;
      pixel_expect_q.delete();
    end else begin
      // Results trail their requests by the result register, so the result
      // side is settled before this edge's request is traced.
      if (rsp_valid && rsp_ready) begin
        if (pixel_expect_q.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %h",
                   $time, rsp);
          fail_count++;
        end else begin
          want = pixel_expect_q.pop_front();
          check_field("pixel_valid", want.pixel_valid, rsp.pixel_valid);
          check_field("pixel_x", want.pixel_x, rsp.pixel_x);
          check_field("pixel_y", want.pixel_y, rsp.pixel_y);
          check_field("plot", want.plot, rsp.plot);
          check_field("last_pixel", want.last_pixel, rsp.last_pixel);
        end
      end
      if (req_valid && req_ready) pixel_expect_q.push_back(trace_pixel(req));
    end
    open_count = pixel_expect_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Line stepper testbench
// Drives directed lines with every pattern, then random
// lines with random lengths and noise requests, with random stalls on both
// channels and long result hold-offs that back the stepper up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TOTAL_ITEMS = 900;
  localparam int unsigned CALM_FROM   = 800;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned STALL_LIMIT = 2000;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  bls_pkg::req_item_t req       = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  bls_pkg::rsp_item_t rsp;

  int unsigned fail_count, open_count;
  int unsigned sent        = 0;
  int unsigned idle_cycles = 0;
  logic        calm        = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bresenham_line_stepper_patterned u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  bls_pixel_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  function automatic bls_pkg::req_item_t step_req();
    bls_pkg::req_item_t r;
    // Coordinates and pattern are don't-care on a step, so they carry noise.
    r.req_type     = bls_pkg::REQ_STEP;
    r.from_x       = bls_pkg::coord_t'($urandom);
    r.from_y       = bls_pkg::coord_t'($urandom);
    r.to_x         = bls_pkg::coord_t'($urandom);
    r.to_y         = bls_pkg::coord_t'($urandom);
    r.pattern_kind = bls_pkg::pattern_t'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic bls_pkg::req_item_t start_req(input int fx, input int fy,
                                                   input int tx, input int ty,
                                                   input bls_pkg::pattern_t pat);
    bls_pkg::req_item_t r;
    r.req_type     = bls_pkg::REQ_START;
    r.from_x       = bls_pkg::coord_t'(fx);
    r.from_y       = bls_pkg::coord_t'(fy);
    r.to_x         = bls_pkg::coord_t'(tx);
    r.to_y         = bls_pkg::coord_t'(ty);
    r.pattern_kind = pat;
    return r;
  endfunction

  task automatic offer(input bls_pkg::req_item_t item);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent++;
  endtask

  initial begin : stimulus
    bls_pkg::req_item_t item;
    int                 fx, fy, tx, ty, dx, dy, reach, span, n;
    int unsigned        guard;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (rst);

    // Step with no line, then single-pixel lines at both corners.
    offer(step_req());
    offer(start_req(0, 0, 0, 0, bls_pkg::PAT_SOLID));
    offer(step_req());
    offer(step_req());
    offer(start_req(4095, 4095, 4095, 4095, bls_pkg::PAT_NONE));
    offer(step_req());
    // Full-width horizontal line, dropped by a steep line going left.
    offer(start_req(0, 0, 4095, 0, bls_pkg::PAT_DOTTED));
    repeat (2) offer(step_req());
    offer(start_req(4095, 0, 4093, 4095, bls_pkg::PAT_SOLID));
    repeat (2) offer(step_req());
    // Shallow leftward line run to its end through the dash wrap.
    offer(start_req(100, 200, 89, 205, bls_pkg::PAT_DASHED));
    repeat (12) offer(step_req());

    while (sent < TOTAL_ITEMS) begin
      if (sent >= CALM_FROM) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        item          = step_req();
        item.req_type = bls_pkg::req_kind_t'($urandom_range(0, 1));
        offer(item);
      end else begin
        reach = ($urandom_range(0, 7) == 0) ? 60 : 12;
        fx    = $urandom_range(0, 4095);
        fy    = $urandom_range(0, 4095);
        dx    = int'($urandom_range(0, 2 * reach)) - reach;
        dy    = int'($urandom_range(0, 2 * reach)) - reach;
        tx    = fx + dx;
        ty    = fy + dy;
        if (tx < 0 || tx > 4095) tx = fx - dx;
        if (ty < 0 || ty > 4095) ty = fy - dy;
        span  = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) ?
                (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
        // Usually run to the end point or past it; sometimes abandon the line early.
        if ($urandom_range(0, 4) == 0) n = $urandom_range(0, span + 1);
        else n = span + 1 + $urandom_range(0, 2);
        offer(start_req(fx, fy, tx, ty, bls_pkg::pattern_t'($urandom_range(0, 3))));
        repeat (n) offer(step_req());
      end
    end
    req_valid <= 1'b0;

    guard = 0;
    do begin
      @(negedge clk);
      guard++;
    end while (open_count != 0 && guard < 1000);
    repeat (4) @(posedge clk);
    if (open_count != 0)
      $display("%0t: %0d expected results never arrived", $time, open_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: short random stalls, plus long hold-offs while requests keep
  // coming so that the stepper fills and stalls its input.
  initial begin : rsp_side
    int unsigned taken, next_hold;
    taken     = 0;
    next_hold = 250;
    do @(posedge clk); while (rst);
    forever begin
      if (!calm && taken >= next_hold) begin
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        next_hold += 350;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      if (rsp_valid) taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hdl/bls_pkg.sv
hdl/bls_engine.sv
hdl/bls_out_reg.sv
hdl/bresenham_line_stepper_patterned.sv
tb/bls_pixel_checker.sv
tb/tb_top.sv
